@@ hw/rtl/ffca_pkg.sv @@
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared constants, codes and control/status types of the first-fit
// coalescing allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int MAX_CHUNKS = 64;
	localparam int ADDR_BITS  = 24;
	localparam int LEN_W      = ADDR_BITS + 1;
	localparam int IDX_W      = $clog2(MAX_CHUNKS);
	localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
	localparam int ENT_W      = ADDR_BITS + LEN_W;
	localparam int HDR_BYTES  = 5;
	localparam int OFF_W      = 8;
	localparam int LG_W       = 3;
	localparam int ST_W       = 2;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FCHK,
		S_ARD,
		S_ACMP,
		S_RRD,
		S_RWR,
		S_FRD,
		S_FCMP,
		S_FDEC,
		S_IRD,
		S_IWR,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		W_NONE,
		W_TRIM,
		W_MOVE,
		W_BOTH,
		W_LEFT,
		W_RIGHT,
		W_NEW
	} wsel_t;

	typedef enum logic [1:0] {
		R_CUR,
		R_NEXT,
		R_PREV
	} rsel_t;

	typedef struct packed {
		logic  load;
		logic  idx_inc;
		logic  idx_dec;
		logic  idx_pos;
		logic  idx_cnt;
		logic  grant;
		logic  scan;
		logic  cnt_inc;
		logic  cnt_dec;
		logic  stat_oom;
		logic  stat_full;
		logic  out_load;
		rsel_t rsel;
		wsel_t wsel;
	} ctl_t;

	typedef struct packed {
		logic is_free;
		logic idx_end;
		logic fit;
		logic trim_zero;
		logic free_bad;
		logic overlap;
		logic lt;
		logic rt;
		logic full;
		logic last_rm;
		logic at_pos;
		logic out_free;
	} sts_t;

endpackage

@@ hw/rtl/ffca_ram.sv @@
// ----------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/ffca_dp.sv @@
// ----------------------------------------------------------------------------
// ffca_dp
// Datapath: chunk list memory, request registers, fit and merge arithmetic,
// result register.
// ----------------------------------------------------------------------------
module ffca_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ffca_pkg::LEN_W-1:0]      cfg_wdata,
	input  logic                            cmd,
	input  logic [ffca_pkg::ADDR_BITS-1:0]  req_size,
	input  logic [ffca_pkg::LG_W-1:0]       align_log2,
	input  logic [ffca_pkg::ADDR_BITS-1:0]  free_addr,
	input  logic [ffca_pkg::OFF_W-1:0]      free_offset,
	input  ffca_pkg::ctl_t                  ctl,
	output ffca_pkg::sts_t                  sts,
	input  logic                            m_ready,
	output logic                            m_valid,
	output logic [ffca_pkg::ADDR_BITS-1:0]  addr_out,
	output logic [ffca_pkg::OFF_W-1:0]      offset_out,
	output logic [ffca_pkg::ST_W-1:0]       status
);

	localparam int AB = ffca_pkg::ADDR_BITS;
	localparam int LW = ffca_pkg::LEN_W;
	localparam int CW = ffca_pkg::CNT_W;
	localparam int IW = ffca_pkg::IDX_W;
	localparam int OW = ffca_pkg::OFF_W;
	localparam logic [LW-1:0] POOL_LIMIT = LW'(1) << AB;

	logic [LW-1:0]           pool_q;
	logic [CW-1:0]           cnt_q, idx_q, pos_q;
	logic                    e0_q, rd0_s1;
	logic                    cmd_q, bad_q, lv_q, rv_q;
	logic [AB-1:0]           size_q, rs_q, l_start_q, r_start_q;
	logic [LW-1:0]           rl_q, l_len_q, r_len_q;
	logic [ffca_pkg::LG_W-1:0] lg_q;
	logic [AB-1:0]           res_addr_q;
	logic [OW-1:0]           res_off_q;
	ffca_pkg::status_t       res_stat_q;
	logic                    m_valid_q;
	logic [AB-1:0]           addr_out_q;
	logic [OW-1:0]           off_out_q;
	logic [ffca_pkg::ST_W-1:0] stat_out_q;

	logic                    we;
	logic [IW-1:0]           waddr, raddr;
	logic [ffca_pkg::ENT_W-1:0] wdata, rdata;
	logic [AB-1:0]           rd_start;
	logic [LW-1:0]           rd_len;

	logic [7:0]              amask;
	logic [LW-1:0]           a_sum, aligned, new_len;
	logic [LW:0]             span;
	logic [AB-1:0]           new_start;

	logic [AB-1:0]           f_rs;
	logic [LW-1:0]           f_rl;
	logic [LW:0]             f_end, rend, l_end, rd_end;

	ffca_ram #(
		.WIDTH(ffca_pkg::ENT_W),
		.DEPTH(ffca_pkg::MAX_CHUNKS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// entry 0 reads as the whole pool until first written
	assign rd_start = rd0_s1 ? '0 : rdata[ffca_pkg::ENT_W-1 -: AB];
	assign rd_len   = rd0_s1 ? pool_q : rdata[LW-1:0];

	always_comb begin
		case (ctl.rsel)
			ffca_pkg::R_NEXT: raddr = IW'(idx_q + 1'b1);
			ffca_pkg::R_PREV: raddr = IW'(idx_q - 1'b1);
			default:          raddr = IW'(idx_q);
		endcase
	end

	// alloc fit
	assign amask     = 8'((9'd1 << lg_q) - 9'd1);
	assign a_sum     = {1'b0, rd_start} + LW'(ffca_pkg::HDR_BYTES) + LW'(amask);
	assign aligned   = a_sum & ~LW'(amask);
	assign span      = {1'b0, aligned} + (LW+1)'(size_q) - (LW+1)'(rd_start);
	assign new_len   = rd_len - span[LW-1:0];
	assign new_start = AB'(aligned + LW'(size_q));

	// free region
	assign f_rs  = free_addr - AB'(free_offset);
	assign f_rl  = LW'(free_offset) + LW'(req_size);
	assign f_end = (LW+1)'(f_rs) + (LW+1)'(f_rl);
	assign rend  = (LW+1)'(rs_q) + (LW+1)'(rl_q);
	assign l_end = (LW+1)'(l_start_q) + (LW+1)'(l_len_q);
	assign rd_end = (LW+1)'(rd_start) + (LW+1)'(rd_len);

	always_comb begin
		sts.is_free   = cmd_q;
		sts.idx_end   = (idx_q == cnt_q);
		sts.fit       = (span <= {1'b0, rd_len});
		sts.trim_zero = (new_len == '0);
		sts.free_bad  = bad_q;
		sts.overlap   = ((LW+1)'(rd_start) < rend) && ((LW+1)'(rs_q) < rd_end);
		sts.lt        = lv_q && (l_end == (LW+1)'(rs_q));
		sts.rt        = rv_q && (rend == (LW+1)'(r_start_q));
		sts.full      = (cnt_q == CW'(ffca_pkg::MAX_CHUNKS));
		sts.last_rm   = (CW'(idx_q + 1'b1) == cnt_q);
		sts.at_pos    = (idx_q == pos_q);
		sts.out_free  = !m_valid_q || m_ready;
	end

	always_comb begin
		we    = (ctl.wsel != ffca_pkg::W_NONE);
		waddr = IW'(idx_q);
		wdata = {rd_start, rd_len};
		case (ctl.wsel)
			ffca_pkg::W_TRIM: begin
				wdata = {new_start, new_len};
			end
			ffca_pkg::W_BOTH: begin
				waddr = IW'(pos_q - 1'b1);
				wdata = {l_start_q, LW'(l_len_q + rl_q + r_len_q)};
			end
			ffca_pkg::W_LEFT: begin
				waddr = IW'(pos_q - 1'b1);
				wdata = {l_start_q, LW'(l_len_q + rl_q)};
			end
			ffca_pkg::W_RIGHT: begin
				waddr = IW'(pos_q);
				wdata = {rs_q, LW'(r_len_q + rl_q)};
			end
			ffca_pkg::W_NEW: begin
				waddr = IW'(pos_q);
				wdata = {rs_q, rl_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q    <= POOL_LIMIT;
			cnt_q     <= CW'(1);
			e0_q      <= 1'b1;
			rd0_s1    <= 1'b0;
			idx_q     <= '0;
			pos_q     <= '0;
			lv_q      <= 1'b0;
			rv_q      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			rd0_s1 <= (raddr == '0) && e0_q;
			if (cfg_we) begin
				pool_q <= (cfg_wdata > POOL_LIMIT) ? POOL_LIMIT : cfg_wdata;
				cnt_q  <= (cfg_wdata != '0) ? CW'(1) : '0;
				e0_q   <= 1'b1;
			end else begin
				if (we && waddr == '0) begin
					e0_q <= 1'b0;
				end
				if (ctl.cnt_inc) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (ctl.cnt_dec) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (ctl.load) begin
				idx_q <= '0;
				pos_q <= '0;
				lv_q  <= 1'b0;
				rv_q  <= 1'b0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end else if (ctl.idx_dec) begin
				idx_q <= idx_q - 1'b1;
			end else if (ctl.idx_pos) begin
				idx_q <= pos_q;
			end else if (ctl.idx_cnt) begin
				idx_q <= cnt_q;
			end
			if (ctl.scan) begin
				if ((LW+1)'(rd_start) <= (LW+1)'(rs_q)) begin
					lv_q  <= 1'b1;
					pos_q <= idx_q + 1'b1;
				end else if (!rv_q) begin
					rv_q <= 1'b1;
				end
			end
			if (ctl.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= cmd;
			size_q     <= req_size;
			lg_q       <= align_log2;
			rs_q       <= f_rs;
			rl_q       <= f_rl;
			bad_q      <= (AB'(free_offset) > free_addr) || (f_rl == '0) ||
			              (f_end > (LW+1)'(pool_q));
			res_addr_q <= '0;
			res_off_q  <= '0;
			res_stat_q <= ffca_pkg::ST_OK;
		end
		if (ctl.scan) begin
			if ((LW+1)'(rd_start) <= (LW+1)'(rs_q)) begin
				l_start_q <= rd_start;
				l_len_q   <= rd_len;
			end else if (!rv_q) begin
				r_start_q <= rd_start;
				r_len_q   <= rd_len;
			end
		end
		if (ctl.grant) begin
			res_addr_q <= aligned[AB-1:0];
			res_off_q  <= OW'(aligned - {1'b0, rd_start});
		end
		if (ctl.stat_oom) begin
			res_stat_q <= ffca_pkg::ST_OOM;
		end
		if (ctl.stat_full) begin
			res_stat_q <= ffca_pkg::ST_FULL;
		end
		if (ctl.out_load) begin
			addr_out_q <= res_addr_q;
			off_out_q  <= res_off_q;
			stat_out_q <= res_stat_q;
		end
	end

	assign m_valid    = m_valid_q;
	assign addr_out   = addr_out_q;
	assign offset_out = off_out_q;
	assign status     = stat_out_q;

endmodule

@@ hw/rtl/ffca_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffca_ctrl
// Controller: sequences list scans, shifts, merges and the result handoff.
// ----------------------------------------------------------------------------
module ffca_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ffca_pkg::sts_t sts,
	output ffca_pkg::ctl_t ctl
);

	ffca_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffca_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffca_pkg::S_IDLE: if (in_valid) state_d = ffca_pkg::S_FCHK;
			ffca_pkg::S_FCHK: begin
				if (!sts.is_free) state_d = ffca_pkg::S_ARD;
				else if (sts.free_bad) state_d = ffca_pkg::S_FIN;
				else state_d = ffca_pkg::S_FRD;
			end
			ffca_pkg::S_ARD: state_d = sts.idx_end ? ffca_pkg::S_FIN : ffca_pkg::S_ACMP;
			ffca_pkg::S_ACMP: begin
				if (!sts.fit) state_d = ffca_pkg::S_ARD;
				else if (sts.trim_zero) state_d = ffca_pkg::S_RRD;
				else state_d = ffca_pkg::S_FIN;
			end
			ffca_pkg::S_RRD: state_d = sts.last_rm ? ffca_pkg::S_FIN : ffca_pkg::S_RWR;
			ffca_pkg::S_RWR: state_d = ffca_pkg::S_RRD;
			ffca_pkg::S_FRD: state_d = sts.idx_end ? ffca_pkg::S_FDEC : ffca_pkg::S_FCMP;
			ffca_pkg::S_FCMP: state_d = sts.overlap ? ffca_pkg::S_FIN : ffca_pkg::S_FRD;
			ffca_pkg::S_FDEC: begin
				if (sts.lt && sts.rt) state_d = ffca_pkg::S_RRD;
				else if (sts.lt || sts.rt || sts.full) state_d = ffca_pkg::S_FIN;
				else state_d = ffca_pkg::S_IRD;
			end
			ffca_pkg::S_IRD: state_d = sts.at_pos ? ffca_pkg::S_FIN : ffca_pkg::S_IWR;
			ffca_pkg::S_IWR: state_d = ffca_pkg::S_IRD;
			ffca_pkg::S_FIN: if (sts.out_free) state_d = ffca_pkg::S_IDLE;
			default: state_d = ffca_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		ctl.rsel = ffca_pkg::R_CUR;
		ctl.wsel = ffca_pkg::W_NONE;
		in_ready = 1'b0;
		case (state_q)
			ffca_pkg::S_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ffca_pkg::S_ARD: ctl.stat_oom = sts.idx_end;
			ffca_pkg::S_ACMP: begin
				if (sts.fit) begin
					ctl.grant = 1'b1;
					if (!sts.trim_zero) ctl.wsel = ffca_pkg::W_TRIM;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			ffca_pkg::S_RRD: begin
				ctl.rsel    = ffca_pkg::R_NEXT;
				ctl.cnt_dec = sts.last_rm;
			end
			ffca_pkg::S_RWR: begin
				ctl.wsel    = ffca_pkg::W_MOVE;
				ctl.idx_inc = 1'b1;
			end
			ffca_pkg::S_FCMP: begin
				ctl.scan    = !sts.overlap;
				ctl.idx_inc = !sts.overlap;
			end
			ffca_pkg::S_FDEC: begin
				if (sts.lt && sts.rt) begin
					ctl.wsel    = ffca_pkg::W_BOTH;
					ctl.idx_pos = 1'b1;
				end else if (sts.lt) begin
					ctl.wsel = ffca_pkg::W_LEFT;
				end else if (sts.rt) begin
					ctl.wsel = ffca_pkg::W_RIGHT;
				end else if (sts.full) begin
					ctl.stat_full = 1'b1;
				end else begin
					ctl.idx_cnt = 1'b1;
				end
			end
			ffca_pkg::S_IRD: begin
				ctl.rsel = ffca_pkg::R_PREV;
				if (sts.at_pos) begin
					ctl.wsel    = ffca_pkg::W_NEW;
					ctl.cnt_inc = 1'b1;
				end
			end
			ffca_pkg::S_IWR: begin
				ctl.wsel    = ffca_pkg::W_MOVE;
				ctl.idx_dec = 1'b1;
			end
			ffca_pkg::S_FIN: ctl.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/first_fit_coalescing_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// Address-sorted free list allocator with first-fit search and coalescing.
// Each list entry scanned and each entry shifted on removal or insertion costs a registered read of the list memory.
// Throughput: one request at a time, next accepted once the result is queued.
// Reset: list holds one chunk covering 16 MiB, no memory sweep needed.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [24:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // req_size, align_log2, free_addr, free_offset
	input  logic [0:0]  s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // addr_out, offset_out, status
);

	ffca_pkg::ctl_t ctl;
	ffca_pkg::sts_t sts;
	logic [ffca_pkg::ADDR_BITS-1:0] addr_out;
	logic [ffca_pkg::OFF_W-1:0]     offset_out;
	logic [ffca_pkg::ST_W-1:0]      status;

	ffca_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.ctl     (ctl)
	);

	ffca_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (s_tuser[0]),
		.req_size   (s_tdata[23:0]),
		.align_log2 (s_tdata[26:24]),
		.free_addr  (s_tdata[50:27]),
		.free_offset(s_tdata[58:51]),
		.ctl        (ctl),
		.sts        (sts),
		.m_ready    (m_tready),
		.m_valid    (m_tvalid),
		.addr_out   (addr_out),
		.offset_out (offset_out),
		.status     (status)
	);

	assign m_tdata = {6'b0, status, offset_out, addr_out};

endmodule

@@ hw/rtl/ffca_chk.sv @@
// ----------------------------------------------------------------------------
// ffca_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffca_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3)
		else $error("bad status code");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != 2'd0 |-> m_tdata[31:0] == 32'd0)
		else $error("failed request carries an address");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

bind first_fit_coalescing_allocator ffca_chk u_chk (.*);

@@ test/tb_first_fit_coalescing_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_coalescing_allocator
// Self-checking bench for the first-fit coalescing allocator. A directed
// table covers reset state, extremes, bad frees and out-of-memory, then random
// alloc/free traffic runs over several pool sizes. An in-bench free list
// model predicts every result, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_first_fit_coalescing_allocator;

	localparam bit CMD_ALLOC = 1'b0;
	localparam bit CMD_FREE  = 1'b1;
	localparam int HDR       = 5;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic        cmd;
		logic [23:0] size;
		logic [2:0]  lg;
		logic [23:0] faddr;
		logic [7:0]  foff;
	} req_t;

	typedef struct packed {
		logic [23:0] addr;
		logic [7:0]  off;
		logic [1:0]  st;
	} rsp_t;

	typedef struct {
		req_t r;
		bit   known;
		rsp_t e;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [24:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	longint fl_start [ffca_pkg::MAX_CHUNKS];
	longint fl_len [ffca_pkg::MAX_CHUNKS];
	int     fl_cnt;
	longint pool;

	rsp_t   pending_rsp [$];
	req_t   granted [$];
	int     errors;
	longint cycles;
	bit     no_idle;
	row_t   rows [$];

	first_fit_coalescing_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic void list_init(input longint v);
		pool = (v > (64'd1 << ffca_pkg::ADDR_BITS)) ? (64'd1 << ffca_pkg::ADDR_BITS) : v;
		for (int i = 0; i < ffca_pkg::MAX_CHUNKS; i++) begin
			fl_start[i] = 0;
			fl_len[i] = 0;
		end
		fl_cnt = (pool == 0) ? 0 : 1;
		fl_len[0] = pool;
	endfunction

	function automatic void list_remove(input int i);
		for (int k = i; k < fl_cnt - 1; k++) begin
			fl_start[k] = fl_start[k+1];
			fl_len[k] = fl_len[k+1];
		end
		fl_cnt--;
		fl_start[fl_cnt] = 0;
		fl_len[fl_cnt] = 0;
	endfunction

	function automatic rsp_t allocate_or_free(input req_t r);
		rsp_t   o;
		longint al, s, a, span, rs, rl;
		int     pos;
		bit     merged;
		o = '0;
		if (r.cmd == CMD_ALLOC) begin
			al = 64'd1 << r.lg;
			o.st = ffca_pkg::ST_OOM;
			for (int i = 0; i < fl_cnt; i++) begin
				s = fl_start[i];
				a = (s + HDR + al - 1) & ~(al - 1);
				span = a + r.size - s;
				if (span <= fl_len[i]) begin
					o.addr = a[23:0];
					o.off = 8'(a - s);
					o.st = ffca_pkg::ST_OK;
					fl_len[i] -= span;
					fl_start[i] = a + r.size;
					if (fl_len[i] == 0) list_remove(i);
					break;
				end
			end
			return o;
		end
		o.st = ffca_pkg::ST_OK;
		if (r.foff > r.faddr) return o;
		rs = r.faddr - r.foff;
		rl = r.foff + r.size;
		if (rl == 0 || rs + rl > pool) return o;
		for (int i = 0; i < fl_cnt; i++)
			if (fl_start[i] < rs + rl && rs < fl_start[i] + fl_len[i]) return o;
		pos = 0;
		while (pos < fl_cnt && fl_start[pos] <= rs) pos++;
		merged = 0;
		if (pos > 0 && fl_start[pos-1] + fl_len[pos-1] == rs) begin
			fl_len[pos-1] += rl;
			rs = fl_start[pos-1];
			rl = fl_len[pos-1];
			merged = 1;
		end
		if (pos < fl_cnt && rs + rl == fl_start[pos]) begin
			if (merged) begin
				fl_len[pos-1] += fl_len[pos];
				list_remove(pos);
			end else begin
				fl_len[pos] += rl;
				fl_start[pos] = rs;
			end
			merged = 1;
		end
		if (!merged) begin
			if (fl_cnt >= ffca_pkg::MAX_CHUNKS) begin
				o.st = ffca_pkg::ST_FULL;
				return o;
			end
			for (int k = fl_cnt; k > pos; k--) begin
				fl_start[k] = fl_start[k-1];
				fl_len[k] = fl_len[k-1];
			end
			fl_start[pos] = rs;
			fl_len[pos] = rl;
			fl_cnt++;
		end
		return o;
	endfunction

	task automatic send_request(input req_t r, input bit known, input rsp_t e);
		rsp_t p;
		while (!no_idle && $urandom_range(99) < 34) @(posedge clk);
		p = allocate_or_free(r);
		if (known && p !== e) report($sformatf("table row %h predicted %h", r, p));
		pending_rsp = {pending_rsp, (known ? e : p)};
		if (r.cmd == CMD_ALLOC && p.st == ffca_pkg::ST_OK) begin
			r.faddr = p.addr;
			r.foff = p.off;
			granted = {granted, r};
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, r.foff, r.faddr, r.lg, r.size};
		s_tuser <= r.cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[23:0], m_tdata[31:24], m_tdata[33:32]};
			if (pending_rsp.size() == 0) report("response with nothing pending");
			else begin
				want = pending_rsp.pop_front();
				if (got.addr !== want.addr)
					report($sformatf("addr %h want %h", got.addr, want.addr));
				if (got.off !== want.off)
					report($sformatf("offset %h want %h", got.off, want.off));
				if (got.st !== want.st)
					report($sformatf("status %0d want %0d", got.st, want.st));
			end
		end
		m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
	end

	task automatic drain;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_pool(input logic [24:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		list_init(v);
		granted.delete();
	endtask

	function automatic req_t mk(input bit c, input int sz, input int lg,
			input int fa, input int fo);
		req_t r;
		r.cmd = c;
		r.size = 24'(sz);
		r.lg = 3'(lg);
		r.faddr = 24'(fa);
		r.foff = 8'(fo);
		return r;
	endfunction

	task automatic add_row(input req_t r, input bit k, input int a, input int o,
			input ffca_pkg::status_t s);
		row_t w;
		w.r = r;
		w.known = k;
		w.e.addr = 24'(a);
		w.e.off = 8'(o);
		w.e.st = s;
		rows = {rows, w};
	endtask

	task automatic random_phase(input int n, input int maxsz);
		req_t r;
		rsp_t dummy;
		int   k;
		dummy = '0;
		for (int i = 0; i < n; i++) begin
			no_idle = (i >= n / 2 && i < n / 2 + 40);
			r = 60'({$urandom, $urandom});
			k = $urandom_range(99);
			if (k < 50) begin
				r.cmd = CMD_ALLOC;
				if (k < 45) r.size = 24'($urandom_range(maxsz));
			end else if (k < 85 && granted.size() != 0) begin
				int j;
				j = $urandom_range(granted.size() - 1);
				r = granted[j];
				granted.delete(j);
				r.cmd = CMD_FREE;
			end else begin
				r.cmd = CMD_FREE;
				if (k < 95) begin
					r.size = 24'($urandom_range(maxsz));
					r.faddr = 24'($urandom_range(32'(pool > 0 ? pool - 1 : 0)));
				end
			end
			send_request(r, 1'b0, dummy);
		end
		no_idle = 0;
	endtask

	initial begin
		req_t r;
		errors = 0;
		cycles = 0;
		no_idle = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		list_init(25'd16777216);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first alloc after reset lands right after the header
		add_row(mk(CMD_ALLOC, 16, 0, 0, 0), 1, 5, 5, ffca_pkg::ST_OK);
		add_row(mk(CMD_ALLOC, 16, 7, 0, 0), 1, 128, 107, ffca_pkg::ST_OK);
		add_row(mk(CMD_ALLOC, 24'hFFFFFF, 0, 0, 0), 1, 0, 0, ffca_pkg::ST_OOM);
		add_row(mk(CMD_FREE, 16, 0, 128, 107), 1, 0, 0, ffca_pkg::ST_OK);
		add_row(mk(CMD_FREE, 16, 0, 128, 107), 1, 0, 0, ffca_pkg::ST_OK);
		add_row(mk(CMD_FREE, 4, 0, 3, 200), 1, 0, 0, ffca_pkg::ST_OK);
		add_row(mk(CMD_FREE, 0, 0, 50, 0), 1, 0, 0, ffca_pkg::ST_OK);
		add_row(mk(CMD_FREE, 24'hFFFFFF, 7, 24'hFFFFFF, 255), 1, 0, 0, ffca_pkg::ST_OK);
		add_row(mk(CMD_FREE, 16, 0, 5, 5), 0, 0, 0, ffca_pkg::ST_OK);
		add_row(mk(CMD_ALLOC, 100, 3, 0, 0), 0, 0, 0, ffca_pkg::ST_OK);
		add_row(mk(CMD_ALLOC, 0, 5, 0, 0), 0, 0, 0, ffca_pkg::ST_OK);
		foreach (rows[i]) send_request(rows[i].r, rows[i].known, rows[i].e);

		random_phase(120, 4096);
		write_pool(25'd0);
		r = mk(CMD_ALLOC, 0, 0, 0, 0);
		send_request(r, 1, '{addr: 0, off: 0, st: ffca_pkg::ST_OOM});
		write_pool(25'h1FFFFFF);
		random_phase(120, 24'hFFFFFF);
		write_pool(25'd1);
		random_phase(20, 8);
		write_pool(25'd2000);
		// fill the list with scattered frees so full is reached
		for (int i = 0; i < 140; i++) send_request(mk(CMD_ALLOC, 3, 0, 0, 0), 0, '0);
		for (int i = 0; i < 140; i += 2) begin
			r = granted[i];
			r.cmd = CMD_FREE;
			send_request(r, 0, '0);
		end
		granted.delete();
		random_phase(60, 64);
		write_pool(25'd16777216);
		random_phase(100, 1 << 16);
		drain();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ first_fit_coalescing_allocator.f @@
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_ram.sv
hw/rtl/ffca_dp.sv
hw/rtl/ffca_ctrl.sv
hw/rtl/first_fit_coalescing_allocator.sv
hw/rtl/ffca_chk.sv
test/tb_first_fit_coalescing_allocator.sv
